// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of the project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at each rising clock edge, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at each rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/crg_pkg.sv =====
// ---------------------------------------------------------------------------
// Circle raster generator package
// Shared widths, operation codes and slot limits.
// ---------------------------------------------------------------------------
package crg_pkg;

  localparam int unsigned COORD_BITS_DEF  = 11;
  localparam int unsigned RADIUS_BITS_DEF = 10;

  localparam int unsigned XY_W        = 13;
  localparam int unsigned OUT_W       = 3 * XY_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam int unsigned SLOT_W = 3;
  localparam logic [SLOT_W-1:0] SLOT_LAST_FILL    = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_LAST_OUTLINE = SLOT_W'(7);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

endpackage

// ===== src/circle_raster_generator_core.sv =====
// A step word is registered into the word issue stage, and each result word into the result register.
// A start word yields no result word; a step word yields eight in outline mode and four in fill mode,
// issued through the single result register (one word per cycle unless m_axis_tready stalls it).
// The next step is accepted in the cycle its predecessor's last word is issued.
// Reset (rst_ni low, asynchronous) clears the circle state: no circle is active.
// ---------------------------------------------------------------------------
// Circle raster generator core
// Andres circle rasterizer: start loads a circle, each step issues points or spans.
// ---------------------------------------------------------------------------
module circle_raster_generator_core import crg_pkg::*; #(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEF,
  localparam int unsigned InW        = 2 * COORD_BITS + RADIUS_BITS + 1,
  localparam int unsigned InTdataW   = ((InW + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // center_x, center_y, radius_in, fill_mode, zero pad
  input  logic [InTdataW-1:0]    s_axis_tdata,
  // operation
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // x_start, x_end, row, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  // done_res
  output logic                   m_axis_tuser
);

  localparam int unsigned SumW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
  localparam int unsigned DecW = RADIUS_BITS + 3;
  localparam int unsigned NxyW = RADIUS_BITS + 2;

  // input fields
  logic [COORD_BITS-1:0]  in_cx, in_cy;
  logic [RADIUS_BITS-1:0] in_rad;
  logic                   in_fill;
  logic                   in_fire, start_fire, step_fire;

  assign in_cx   = s_axis_tdata[COORD_BITS-1:0];
  assign in_cy   = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_rad  = s_axis_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
  assign in_fill = s_axis_tdata[2*COORD_BITS+RADIUS_BITS];

  // circle state
  logic                   active_q, active_d;
  logic                   fill_q, fill_d;
  logic [COORD_BITS-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic [RADIUS_BITS-1:0] rad_q, rad_d, offx_q, offx_d, offy_q, offy_d;
  logic signed [DecW-1:0] dec_q, dec_d;

  // word issue stage
  logic                   busy_q, busy_d;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic                   em_fill_q, em_done_q;
  logic [COORD_BITS-1:0]  em_cx_q, em_cy_q;
  logic [RADIUS_BITS-1:0] em_a_q, em_b_q;

  // result register
  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic                   m_last_q, m_done_q;

  logic out_ready, emit, last_slot;

  assign out_ready     = !m_valid_q || m_axis_tready;
  assign last_slot     = em_fill_q ? (slot_q == SLOT_LAST_FILL) : (slot_q == SLOT_LAST_OUTLINE);
  assign emit          = busy_q && out_ready;
  assign s_axis_tready = !busy_q || (out_ready && last_slot);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign start_fire    = in_fire && (s_axis_tuser == OP_START);
  assign step_fire     = in_fire && (s_axis_tuser == OP_STEP) && active_q;

  // decision rule
  logic signed [DecW-1:0] two_a, two_b, two_rb;
  logic signed [DecW-1:0] nd_x, nd_y, nd_xy, nd;
  logic signed [NxyW-1:0] ox_s, oy_s, nx, ny;
  logic                   done;

  assign two_a  = signed'(DecW'({offx_q, 1'b0}));
  assign two_b  = signed'(DecW'({offy_q, 1'b0}));
  assign two_rb = signed'(DecW'({rad_q - offy_q, 1'b0}));
  assign nd_x   = dec_q - two_a - DecW'(1);
  assign nd_y   = dec_q + two_b - DecW'(1);
  assign nd_xy  = dec_q + two_b - two_a - DecW'(2);
  assign ox_s   = signed'(NxyW'(offx_q));
  assign oy_s   = signed'(NxyW'(offy_q));

  always_comb begin
    if (dec_q >= two_a) begin
      nd = nd_x;
      nx = ox_s + NxyW'(1);
      ny = oy_s;
    end else if (dec_q < two_rb) begin
      nd = nd_y;
      nx = ox_s;
      ny = oy_s - NxyW'(1);
    end else begin
      nd = nd_xy;
      nx = ox_s + NxyW'(1);
      ny = oy_s - NxyW'(1);
    end
  end

  assign done = ny < nx;

  always_comb begin
    active_d = active_q;
    fill_d   = fill_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    rad_d    = rad_q;
    offx_d   = offx_q;
    offy_d   = offy_q;
    dec_d    = dec_q;
    if (start_fire) begin
      active_d = 1'b1;
      fill_d   = in_fill;
      cx_d     = in_cx;
      cy_d     = in_cy;
      rad_d    = in_rad;
      offx_d   = '0;
      offy_d   = in_rad;
      dec_d    = signed'(DecW'(in_rad)) - DecW'(1);
    end else if (step_fire) begin
      if (done) begin
        active_d = 1'b0;
        offx_d   = '0;
        offy_d   = '0;
        dec_d    = '0;
      end else begin
        offx_d   = nx[RADIUS_BITS-1:0];
        offy_d   = ny[RADIUS_BITS-1:0];
        dec_d    = nd;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    if (emit) begin
      slot_d = slot_q + SLOT_W'(1);
      if (last_slot) begin
        busy_d = 1'b0;
      end
    end
    if (step_fire) begin
      busy_d = 1'b1;
      slot_d = '0;
    end
  end

  assign m_valid_d = emit || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      fill_q    <= 1'b0;
      cx_q      <= '0;
      cy_q      <= '0;
      rad_q     <= '0;
      offx_q    <= '0;
      offy_q    <= '0;
      dec_q     <= '0;
      busy_q    <= 1'b0;
      slot_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      fill_q    <= fill_d;
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      rad_q     <= rad_d;
      offx_q    <= offx_d;
      offy_q    <= offy_d;
      dec_q     <= dec_d;
      busy_q    <= busy_d;
      slot_q    <= slot_d;
      m_valid_q <= m_valid_d;
    end
  end

  // snapshot of the offsets that the step works on
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      em_fill_q <= fill_q;
      em_done_q <= done;
      em_cx_q   <= cx_q;
      em_cy_q   <= cy_q;
      em_a_q    <= offx_q;
      em_b_q    <= offy_q;
    end
  end

  // point and span coordinates
  logic signed [SumW-1:0] ex_cx, ex_cy, ex_a, ex_b;
  logic signed [SumW-1:0] cx_pa, cx_ma, cx_pb, cx_mb, cy_pa, cy_ma, cy_pb, cy_mb;
  logic signed [XY_W-1:0] xs, xe, rw;

  assign ex_cx = signed'(SumW'(em_cx_q));
  assign ex_cy = signed'(SumW'(em_cy_q));
  assign ex_a  = signed'(SumW'(em_a_q));
  assign ex_b  = signed'(SumW'(em_b_q));
  assign cx_pa = ex_cx + ex_a;
  assign cx_ma = ex_cx - ex_a;
  assign cx_pb = ex_cx + ex_b;
  assign cx_mb = ex_cx - ex_b;
  assign cy_pa = ex_cy + ex_a;
  assign cy_ma = ex_cy - ex_a;
  assign cy_pb = ex_cy + ex_b;
  assign cy_mb = ex_cy - ex_b;

  always_comb begin
    xs = XY_W'(cx_pa);
    xe = XY_W'(cx_pa);
    rw = XY_W'(cy_pb);
    if (em_fill_q) begin
      case (slot_q[1:0])
        2'd0: begin
          xs = XY_W'(cx_mb);
          xe = XY_W'(cx_pb);
          rw = XY_W'(cy_pa);
        end
        2'd1: begin
          xs = XY_W'(cx_ma);
          xe = XY_W'(cx_pa);
          rw = XY_W'(cy_pb);
        end
        2'd2: begin
          xs = XY_W'(cx_ma);
          xe = XY_W'(cx_pa);
          rw = XY_W'(cy_mb);
        end
        default: begin
          xs = XY_W'(cx_mb);
          xe = XY_W'(cx_pb);
          rw = XY_W'(cy_ma);
        end
      endcase
    end else begin
      case (slot_q)
        3'd0: begin
          xs = XY_W'(cx_pa);
          rw = XY_W'(cy_pb);
        end
        3'd1: begin
          xs = XY_W'(cx_pb);
          rw = XY_W'(cy_pa);
        end
        3'd2: begin
          xs = XY_W'(cx_ma);
          rw = XY_W'(cy_pb);
        end
        3'd3: begin
          xs = XY_W'(cx_mb);
          rw = XY_W'(cy_pa);
        end
        3'd4: begin
          xs = XY_W'(cx_pa);
          rw = XY_W'(cy_mb);
        end
        3'd5: begin
          xs = XY_W'(cx_pb);
          rw = XY_W'(cy_ma);
        end
        3'd6: begin
          xs = XY_W'(cx_ma);
          rw = XY_W'(cy_mb);
        end
        default: begin
          xs = XY_W'(cx_mb);
          rw = XY_W'(cy_ma);
        end
      endcase
      xe = xs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= OUT_TDATA_W'({rw, xe, xs});
      m_last_q <= last_slot;
      m_done_q <= last_slot && em_done_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_done_q;

endmodule

// ===== src/crg_checker.sv =====
// ---------------------------------------------------------------------------
// Circle raster generator checker
// Port-level assertions on the result stream and the input ready, bound to the core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module crg_checker import crg_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic                   m_axis_tuser
);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "result word changed while stalled")

  `ASSERT_CLK(a_done_on_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "done flagged on a word that is not last")

  `ASSERT_CLK(a_busy_issues, clk_i, rst_ni, !s_axis_tready |=> m_axis_tvalid, "input held off with no result word pending")

  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !m_axis_tvalid && s_axis_tready, "core not idle after reset")

endmodule

bind circle_raster_generator_core crg_checker u_crg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
